### hw/rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
`default_nettype none

package spq_pkg;

    // Fixed field widths of the request and response words
    localparam int FUNC_W   = 2;
    localparam int KEY_W    = 16;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    // Operation codes; code 3 does nothing
    typedef logic [FUNC_W-1:0] t_func;
    localparam t_func FUNC_INSERT = 2'd0;
    localparam t_func FUNC_DELETE = 2'd1;
    localparam t_func FUNC_PEEK   = 2'd2;

    // Response status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } t_status;

    // Controller states, one-hot
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_HOLD = 2'b10
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic  insert;
        logic  pop;
        logic  load;
        t_func func;
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
    } t_dp_stat;

endpackage

`default_nettype wire

### hw/rtl/spq_req_if.sv
// Request channel: operation, key and payload with valid/ready.
`default_nettype none

interface spq_req_if;
    logic                         valid;
    logic                         ready;
    logic [spq_pkg::FUNC_W-1:0]   func;
    logic [spq_pkg::KEY_W-1:0]    new_key;
    logic [spq_pkg::VALUE_W-1:0]  new_value;

    modport source (output valid, output func, output new_key, output new_value,
                    input ready);
    modport sink   (input valid, input func, input new_key, input new_value,
                    output ready);
endinterface

`default_nettype wire

### hw/rtl/spq_rsp_if.sv
// Response channel: status, head entry and occupancy with valid/ready.
`default_nettype none

interface spq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [spq_pkg::STATUS_W-1:0]  status;
    logic [spq_pkg::KEY_W-1:0]     out_key;
    logic [spq_pkg::VALUE_W-1:0]   out_value;
    logic                          is_empty;
    logic [spq_pkg::OCC_W-1:0]     occupancy;

    modport source (output valid, output status, output out_key, output out_value,
                    output is_empty, output occupancy, input ready);
    modport sink   (input valid, input status, input out_key, input out_value,
                    input is_empty, input occupancy, output ready);
endinterface

`default_nettype wire

### hw/rtl/spq_ctrl.sv
// Handshake controller: accepts requests and holds the response word.
`default_nettype none

module spq_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire spq_pkg::t_func     i_func,
    output logic                    o_in_ready,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    input  wire spq_pkg::t_dp_stat  i_stat,
    output spq_pkg::t_dp_cmd        o_cmd
);

    spq_pkg::t_state r_state, n_state;
    logic            w_accept;

    // A new word may enter when no response waits or it leaves this cycle
    assign o_in_ready  = (r_state == spq_pkg::ST_IDLE) || i_out_ready;
    assign o_out_valid = (r_state == spq_pkg::ST_HOLD);
    assign w_accept    = i_in_valid && o_in_ready;

    // Command decode
    always_comb begin
        o_cmd.func   = i_func;
        o_cmd.load   = w_accept;
        o_cmd.insert = w_accept && (i_func == spq_pkg::FUNC_INSERT) && !i_stat.full;
        o_cmd.pop    = w_accept && (i_func == spq_pkg::FUNC_DELETE) && !i_stat.empty;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            spq_pkg::ST_IDLE: begin
                if (w_accept) n_state = spq_pkg::ST_HOLD;
            end
            spq_pkg::ST_HOLD: begin
                if (i_out_ready && !w_accept) n_state = spq_pkg::ST_IDLE;
            end
            default: n_state = spq_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/spq_dp.sv
// Datapath: sorted register chain of entries and the response register.
`default_nettype none

module spq_dp #(
    parameter int CAPACITY    = 16,
    parameter int KEY_WIDTH   = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire spq_pkg::t_dp_cmd              i_cmd,
    input  wire logic [spq_pkg::KEY_W-1:0]     i_key,
    input  wire logic [spq_pkg::VALUE_W-1:0]   i_value,
    output spq_pkg::t_dp_stat                  o_stat,
    output logic [spq_pkg::STATUS_W-1:0]       o_status,
    output logic [spq_pkg::KEY_W-1:0]          o_key,
    output logic [spq_pkg::VALUE_W-1:0]        o_value,
    output logic                               o_is_empty,
    output logic [spq_pkg::OCC_W-1:0]          o_occupancy
);

    // Stored widths: the port width bounds what can ever be kept
    localparam int KW    = (KEY_WIDTH < spq_pkg::KEY_W) ? KEY_WIDTH : spq_pkg::KEY_W;
    localparam int VW    = (VALUE_WIDTH < spq_pkg::VALUE_W) ? VALUE_WIDTH
                                                            : spq_pkg::VALUE_W;
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int KOW   = spq_pkg::KEY_W;
    localparam int VOW   = spq_pkg::VALUE_W;
    localparam int OW    = spq_pkg::OCC_W;

    logic [KW-1:0]       r_key [CAPACITY];
    logic [VW-1:0]       r_val [CAPACITY];
    logic [CW-1:0]       r_count, n_count;
    logic [KW-1:0]       w_key;
    logic [VW-1:0]       w_val;
    logic [CAPACITY-1:0] w_le;
    logic                w_head_req;

    spq_pkg::t_status    r_status, n_status;
    logic [KOW-1:0]      r_out_key;
    logic [VOW-1:0]      r_out_val;
    logic                r_is_empty;
    logic [OW-1:0]       r_occ;

    assign w_key = KW'(i_key);
    assign w_val = VW'(i_value);

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CW'(CAPACITY));

    // Slot chain: every slot compares against the new key in parallel
    for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
        logic          take_new;
        logic [KW-1:0] prev_key, next_key;
        logic [VW-1:0] prev_val, next_val;

        // Occupied slot whose key is not above the new key stays put
        assign w_le[i] = (CW'(i) < r_count) && (r_key[i] <= w_key);

        if (i == 0) begin : g_head
            assign take_new = 1'b1;
            assign prev_key = w_key;
            assign prev_val = w_val;
        end else begin : g_body
            assign take_new = w_le[i-1];
            assign prev_key = r_key[i-1];
            assign prev_val = r_val[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign next_key = r_key[i];
            assign next_val = r_val[i];
        end else begin : g_inner
            assign next_key = r_key[i+1];
            assign next_val = r_val[i+1];
        end

        // Insert: first slot above the key takes the new entry, later ones shift down; pop shifts every slot up
        always_ff @(posedge i_clk) begin
            if (i_cmd.insert) begin
                if (!w_le[i]) begin
                    r_key[i] <= take_new ? w_key : prev_key;
                    r_val[i] <= take_new ? w_val : prev_val;
                end
            end else if (i_cmd.pop) begin
                r_key[i] <= next_key;
                r_val[i] <= next_val;
            end
        end
    end

    // Entry count
    always_comb begin
        n_count = r_count;
        if (i_cmd.insert) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Response status
    assign w_head_req = (i_cmd.func == spq_pkg::FUNC_DELETE) ||
                        (i_cmd.func == spq_pkg::FUNC_PEEK);

    always_comb begin
        n_status = spq_pkg::STATUS_OK;
        priority if ((i_cmd.func == spq_pkg::FUNC_INSERT) && o_stat.full) begin
            n_status = spq_pkg::STATUS_FULL;
        end else if (w_head_req && o_stat.empty) begin
            n_status = spq_pkg::STATUS_EMPTY;
        end else begin
            n_status = spq_pkg::STATUS_OK;
        end
    end

    // Response register, loaded once per accepted word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_status   <= n_status;
            r_out_key  <= (w_head_req && !o_stat.empty) ? KOW'(r_key[0]) : '0;
            r_out_val  <= (w_head_req && !o_stat.empty) ? VOW'(r_val[0]) : '0;
            r_is_empty <= (n_count == '0);
            r_occ      <= OW'(n_count);
        end
    end

    assign o_status    = r_status;
    assign o_key       = r_out_key;
    assign o_value     = r_out_val;
    assign o_is_empty  = r_is_empty;
    assign o_occupancy = r_occ;

endmodule

`default_nettype wire

### hw/rtl/sorted_priority_queue_unit.sv
// A response word appears in the cycle after its request is accepted.
// Throughput: one request per cycle while the response side takes every word;
//   the sorted slot chain finishes any insert, delete or peek at the edge that accepts it.
// Reset (synchronous, active low) clears the entry count and the handshake
//   state; slot contents are left as they are and are only read below the count.
`default_nettype none

module sorted_priority_queue_unit #(
    parameter int CAPACITY    = 16,
    parameter int KEY_WIDTH   = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    spq_req_if.sink    i_req,
    spq_rsp_if.source  o_rsp
);

    spq_pkg::t_dp_cmd  w_cmd;
    spq_pkg::t_dp_stat w_stat;

    // Handshake and command sequencing
    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_func      (i_req.func),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // Entry storage and response word
    spq_dp #(
        .CAPACITY    (CAPACITY),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_key       (i_req.new_key),
        .i_value     (i_req.new_value),
        .o_stat      (w_stat),
        .o_status    (o_rsp.status),
        .o_key       (o_rsp.out_key),
        .o_value     (o_rsp.out_value),
        .o_is_empty  (o_rsp.is_empty),
        .o_occupancy (o_rsp.occupancy)
    );

`ifndef SYNTHESIS
    // Chain never shifts both ways at once
    a_no_dual_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.insert && w_cmd.pop))
        else $error("insert and pop issued together");

    // Every accepted word yields a response word in the next cycle
    a_rsp_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |=> o_rsp.valid)
        else $error("response missing after accepted request");

    // An empty-queue response carries no entry and reports an empty queue
    a_empty_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status == spq_pkg::STATUS_EMPTY)) |->
        (o_rsp.is_empty && (o_rsp.out_key == '0) && (o_rsp.out_value == '0)))
        else $error("empty status with entry data or nonzero occupancy");

    // A full rejection leaves the queue non-empty
    a_full_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status == spq_pkg::STATUS_FULL)) |-> !o_rsp.is_empty)
        else $error("full status reported on an empty queue");
`endif

endmodule

`default_nettype wire

### tb/sv/tb_sorted_priority_queue_unit.sv
// Testbench for the sorted priority queue: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_sorted_priority_queue_unit;

    localparam int CAPACITY    = 16;
    localparam int N_RANDOM    = 1700;
    localparam int N_DIRECTED  = 26;
    localparam int HOLD_AT     = 300;   // random word at which the long hold is armed
    localparam int LONG_HOLD   = 120;   // cycles the response side holds off
    localparam int STALL_LIMIT = 2000;  // cycles with no handshake before giving up
    localparam int TAIL_CYCLES = 5;

    // Unused operation code: the block answers it without touching the queue
    localparam spq_pkg::t_func FUNC_NOP = 2'd3;

    localparam int SIDE_REQ = 0;
    localparam int SIDE_RSP = 1;

    typedef enum int {IDLE_NONE, IDLE_FULL, IDLE_SPARSE} t_idle_mode;
    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} t_op_mix;
    typedef enum int {KEYS_NARROW, KEYS_WIDE, KEYS_EDGE} t_key_style;

    typedef struct packed {
        logic [spq_pkg::STATUS_W-1:0] status;
        logic [spq_pkg::KEY_W-1:0]    key;
        logic [spq_pkg::VALUE_W-1:0]  value;
        logic                         empty;
        logic [spq_pkg::OCC_W-1:0]    occ;
    } t_rsp_word;

    typedef struct packed {
        spq_pkg::t_func              func;
        logic [spq_pkg::KEY_W-1:0]   key;
        logic [spq_pkg::VALUE_W-1:0] value;
        logic                        has_exp;   // typed-in response rather than predicted
        t_rsp_word                   exp;
    } t_req_row;

    // Directed words: empty queue, extremes, FIFO order on equal keys, full queue
    localparam t_req_row DIRECTED_ROWS [N_DIRECTED] = '{
        '{spq_pkg::FUNC_PEEK,   16'h0000, 32'h0000_0000, 1'b1,
          '{spq_pkg::STATUS_EMPTY, 16'h0000, 32'h0000_0000, 1'b1, 5'd0}},
        '{spq_pkg::FUNC_DELETE, 16'h0000, 32'h0000_0000, 1'b1,
          '{spq_pkg::STATUS_EMPTY, 16'h0000, 32'h0000_0000, 1'b1, 5'd0}},
        '{spq_pkg::FUNC_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
          '{spq_pkg::STATUS_OK, 16'h0000, 32'h0000_0000, 1'b0, 5'd1}},
        '{spq_pkg::FUNC_INSERT, 16'h0000, 32'h0000_0000, 1'b1,
          '{spq_pkg::STATUS_OK, 16'h0000, 32'h0000_0000, 1'b0, 5'd2}},
        '{spq_pkg::FUNC_PEEK,   16'h0000, 32'h0000_0000, 1'b1,
          '{spq_pkg::STATUS_OK, 16'h0000, 32'h0000_0000, 1'b0, 5'd2}},
        '{spq_pkg::FUNC_DELETE, 16'h0000, 32'h0000_0000, 1'b1,
          '{spq_pkg::STATUS_OK, 16'h0000, 32'h0000_0000, 1'b0, 5'd1}},
        '{spq_pkg::FUNC_DELETE, 16'h0000, 32'h0000_0000, 1'b1,
          '{spq_pkg::STATUS_OK, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 5'd0}},
        '{FUNC_NOP,             16'hFFFF, 32'hFFFF_FFFF, 1'b1,
          '{spq_pkg::STATUS_OK, 16'h0000, 32'h0000_0000, 1'b1, 5'd0}},
        '{spq_pkg::FUNC_INSERT, 16'h8000, 32'hAAAA_AAAA, 1'b0, '0},
        '{spq_pkg::FUNC_INSERT, 16'h0005, 32'h0000_0001, 1'b0, '0},
        '{spq_pkg::FUNC_INSERT, 16'h0005, 32'h0000_0002, 1'b0, '0},
        '{spq_pkg::FUNC_INSERT, 16'hFFFF, 32'h5555_5555, 1'b0, '0},
        '{spq_pkg::FUNC_INSERT, 16'h0001, 32'h1234_5678, 1'b0, '0},
        '{spq_pkg::FUNC_INSERT, 16'h0005, 32'h0000_0003, 1'b0, '0},
        '{spq_pkg::FUNC_INSERT, 16'h7FFF, 32'h8000_0000, 1'b0, '0},
        '{spq_pkg::FUNC_INSERT, 16'h0000, 32'hFFFF_FFFF, 1'b0, '0},
        '{spq_pkg::FUNC_INSERT, 16'h0005, 32'h0000_0004, 1'b0, '0},
        '{spq_pkg::FUNC_INSERT, 16'h1234, 32'h7FFF_FFFF, 1'b0, '0},
        '{spq_pkg::FUNC_INSERT, 16'hFFFE, 32'hCAFE_F00D, 1'b0, '0},
        '{spq_pkg::FUNC_INSERT, 16'h0001, 32'h0F0F_0F0F, 1'b0, '0},
        '{spq_pkg::FUNC_INSERT, 16'h0002, 32'hF0F0_F0F0, 1'b0, '0},
        '{spq_pkg::FUNC_INSERT, 16'h8000, 32'h5555_AAAA, 1'b0, '0},
        '{spq_pkg::FUNC_INSERT, 16'h0003, 32'h0000_0010, 1'b0, '0},
        '{spq_pkg::FUNC_INSERT, 16'h0005, 32'h0000_0005, 1'b1,
          '{spq_pkg::STATUS_OK, 16'h0000, 32'h0000_0000, 1'b0, 5'd16}},
        '{spq_pkg::FUNC_INSERT, 16'h0000, 32'hDEAD_BEEF, 1'b1,
          '{spq_pkg::STATUS_FULL, 16'h0000, 32'h0000_0000, 1'b0, 5'd16}},
        '{FUNC_NOP,             16'h0000, 32'h0000_0000, 1'b1,
          '{spq_pkg::STATUS_OK, 16'h0000, 32'h0000_0000, 1'b0, 5'd16}}
    };

    logic i_clk;
    logic i_rst_n;

    spq_req_if req_bus ();
    spq_rsp_if rsp_bus ();

    sorted_priority_queue_unit #(
        .CAPACITY    (CAPACITY),
        .KEY_WIDTH   (spq_pkg::KEY_W),
        .VALUE_WIDTH (spq_pkg::VALUE_W)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    // Shadow copy of the queue
    logic [spq_pkg::KEY_W-1:0]   shadow_keys   [CAPACITY];
    logic [spq_pkg::VALUE_W-1:0] shadow_values [CAPACITY];
    int                          shadow_count;

    t_req_row  offered_words [$];   // driven on the request side, not yet taken
    t_rsp_word pending_rsp   [$];   // responses still owed by the block

    int         err_count;
    int         rsp_seen;
    bit         stim_done;
    bit         hold_armed;
    t_idle_mode idle_mode [2];
    int         idle_left [2];

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Apply one operation to the shadow queue and give the response it owes
    function automatic t_rsp_word queue_step(spq_pkg::t_func op,
                                             logic [spq_pkg::KEY_W-1:0] key,
                                             logic [spq_pkg::VALUE_W-1:0] value);
        t_rsp_word r;
        int        pos;
        int        i;
        r = '0;
        r.status = spq_pkg::STATUS_OK;
        case (op)
            spq_pkg::FUNC_INSERT: begin
                if (shadow_count >= CAPACITY) begin
                    r.status = spq_pkg::STATUS_FULL;
                end else begin
                    // after every key <= new key, so equal keys stay FIFO
                    pos = 0;
                    while (pos < shadow_count && shadow_keys[pos] <= key) pos++;
                    for (i = shadow_count; i > pos; i--) begin
                        shadow_keys[i]   = shadow_keys[i-1];
                        shadow_values[i] = shadow_values[i-1];
                    end
                    shadow_keys[pos]   = key;
                    shadow_values[pos] = value;
                    shadow_count++;
                end
            end
            spq_pkg::FUNC_DELETE, spq_pkg::FUNC_PEEK: begin
                if (shadow_count == 0) begin
                    r.status = spq_pkg::STATUS_EMPTY;
                end else begin
                    r.key   = shadow_keys[0];
                    r.value = shadow_values[0];
                    if (op == spq_pkg::FUNC_DELETE) begin
                        for (i = 0; i + 1 < shadow_count; i++) begin
                            shadow_keys[i]   = shadow_keys[i+1];
                            shadow_values[i] = shadow_values[i+1];
                        end
                        shadow_count--;
                    end
                end
            end
            default: ;
        endcase
        r.empty = (shadow_count == 0);
        r.occ   = shadow_count[spq_pkg::OCC_W-1:0];
        return r;
    endfunction

    // Idle cycles before the next word; each side runs in stretches of one mode
    function automatic int draw_gap(int side);
        if (idle_left[side] == 0) begin
            idle_mode[side] = t_idle_mode'($urandom_range(0, 2));
            idle_left[side] = $urandom_range(20, 80);
        end
        idle_left[side]--;
        case (idle_mode[side])
            IDLE_NONE: return 0;
            IDLE_FULL: return $urandom_range(0, 10);
            default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
        endcase
    endfunction

    task automatic report_mismatch(string what);
        err_count++;
        $display("[%0t] response %0d: %s", $realtime, rsp_seen, what);
    endtask

    task automatic check_field(string field, longint unsigned got, longint unsigned want);
        if (got != want)
            report_mismatch($sformatf("%s is %0h, expected %0h", field, got, want));
    endtask

    // Offer one request word and wait until the block takes it
    task automatic send_word(t_req_row row);
        int gap;
        gap = draw_gap(SIDE_REQ);
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        offered_words.push_back(row);
        req_bus.valid     <= 1'b1;
        req_bus.func      <= row.func;
        req_bus.new_key   <= row.key;
        req_bus.new_value <= row.value;
        do @(posedge i_clk); while (!req_bus.ready);
    endtask

    // Monitor: predict on every request taken, check every response taken
    always @(posedge i_clk) begin
        t_req_row  row;
        t_rsp_word predicted;
        t_rsp_word want;
        if (i_rst_n) begin
            if (req_bus.valid && req_bus.ready) begin
                row = offered_words.pop_front();
                predicted = queue_step(req_bus.func, req_bus.new_key, req_bus.new_value);
                pending_rsp.push_back(row.has_exp ? row.exp : predicted);
            end
            if (rsp_bus.valid && rsp_bus.ready) begin
                if (pending_rsp.size() == 0) begin
                    report_mismatch("response word with nothing outstanding");
                end else begin
                    want = pending_rsp.pop_front();
                    check_field("status",    64'(rsp_bus.status),    64'(want.status));
                    check_field("out_key",   64'(rsp_bus.out_key),   64'(want.key));
                    check_field("out_value", 64'(rsp_bus.out_value), 64'(want.value));
                    check_field("is_empty",  64'(rsp_bus.is_empty),  64'(want.empty));
                    check_field("occupancy", 64'(rsp_bus.occupancy), 64'(want.occ));
                end
                rsp_seen++;
            end
        end
    end

    // Response side: random stalls, plus one long hold so the block backs up
    initial begin
        int gap;
        rsp_bus.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_armed) begin
                hold_armed = 1'b0;
                rsp_bus.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                gap = draw_gap(SIDE_RSP);
                if (gap > 0) begin
                    rsp_bus.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            rsp_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_bus.valid);
        end
    end

    // Watchdog: too long without any word moving while work is outstanding
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
                (stim_done && offered_words.size() == 0 && pending_rsp.size() == 0))
                quiet = 0;
            else
                quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Stimulus
    initial begin
        t_req_row   row;
        t_op_mix    mix;
        t_key_style key_style;
        int         mix_left;
        int         pick;
        int         n;

        err_count     = 0;
        rsp_seen      = 0;
        stim_done     = 1'b0;
        hold_armed    = 1'b0;
        idle_left     = '{0, 0};
        idle_mode     = '{IDLE_NONE, IDLE_NONE};
        shadow_count  = 0;
        mix           = MIX_EVEN;
        key_style     = KEYS_NARROW;
        mix_left      = 0;
        i_rst_n       = 1'b0;
        req_bus.valid     = 1'b0;
        req_bus.func      = spq_pkg::FUNC_INSERT;
        req_bus.new_key   = '0;
        req_bus.new_value = '0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        for (n = 0; n < N_DIRECTED; n++) send_word(DIRECTED_ROWS[n]);

        // Random traffic in stretches biased to fill, drain or hover
        for (n = 0; n < N_RANDOM; n++) begin
            if (mix_left == 0) begin
                mix       = t_op_mix'($urandom_range(0, 2));
                key_style = t_key_style'($urandom_range(0, 2));
                mix_left  = $urandom_range(10, 60);
            end
            mix_left--;
            if (n == HOLD_AT) hold_armed = 1'b1;

            row = '0;
            pick = $urandom_range(0, 99);
            if (pick < 3)
                row.func = FUNC_NOP;
            else begin
                case (mix)
                    MIX_FILL:  row.func = (pick < 78) ? spq_pkg::FUNC_INSERT :
                                          (pick < 90) ? spq_pkg::FUNC_DELETE :
                                                        spq_pkg::FUNC_PEEK;
                    MIX_DRAIN: row.func = (pick < 20) ? spq_pkg::FUNC_INSERT :
                                          (pick < 80) ? spq_pkg::FUNC_DELETE :
                                                        spq_pkg::FUNC_PEEK;
                    default:   row.func = (pick < 48) ? spq_pkg::FUNC_INSERT :
                                          (pick < 85) ? spq_pkg::FUNC_DELETE :
                                                        spq_pkg::FUNC_PEEK;
                endcase
            end

            case (key_style)
                KEYS_NARROW: row.key = spq_pkg::KEY_W'($urandom_range(0, 7));  // many equal keys
                KEYS_WIDE:   row.key = spq_pkg::KEY_W'($urandom_range(0, 16'hFFFF));
                default: begin
                    case ($urandom_range(0, 4))
                        0:       row.key = 16'h0000;
                        1:       row.key = 16'hFFFF;
                        2:       row.key = 16'h8000;
                        3:       row.key = 16'h7FFF;
                        default: row.key = spq_pkg::KEY_W'($urandom_range(0, 16'hFFFF));
                    endcase
                end
            endcase
            row.value = $urandom;
            send_word(row);
        end
        req_bus.valid <= 1'b0;
        stim_done = 1'b1;

        // Drain, then wait out a quiet tail to catch stray responses
        while (offered_words.size() != 0 || pending_rsp.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### files.f
hw/rtl/spq_pkg.sv
hw/rtl/spq_req_if.sv
hw/rtl/spq_rsp_if.sv
hw/rtl/spq_ctrl.sv
hw/rtl/spq_dp.sv
hw/rtl/sorted_priority_queue_unit.sv
tb/sv/tb_sorted_priority_queue_unit.sv
